>>> src/stereo_feedback_delay_macros.svh
// assertion macros for the stereo feedback delay checker
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stereo_feedback_delay: assertion failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stereo_feedback_delay: assertion failed");

`endif

>>> src/sfd_pkg.sv
// shared types and constants for the stereo feedback delay
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

   localparam int DELAY_BITS     = 17;
   localparam int GAIN_BITS      = 16;
   localparam int FRAC_BITS      = 15;
   localparam int ROUND_BIAS     = 16384;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;

   localparam int DELAY_RESET    = 48000;
   localparam logic [GAIN_BITS-1:0] FEEDBACK_RESET = 16'd16384;
   localparam logic [GAIN_BITS-1:0] DRY_RESET      = 16'd32768;
   localparam logic [GAIN_BITS-1:0] WET_RESET      = 16'd16384;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DELAY    = 8'd0,
      REG_FEEDBACK = 8'd1,
      REG_DRY      = 8'd2,
      REG_WET      = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] feedback;
      logic [GAIN_BITS-1:0] dry;
      logic [GAIN_BITS-1:0] wet;
   } gain_type;

endpackage

`default_nettype wire

>>> src/sfd_req_if.sv
// input frame channel
`timescale 1ns / 1ps
`default_nettype none

interface sfd_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

>>> src/sfd_rsp_if.sv
// result frame channel
`timescale 1ns / 1ps
`default_nettype none

interface sfd_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

>>> src/sfd_csr_if.sv
// register write channel
`timescale 1ns / 1ps
`default_nettype none

interface sfd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sfd_pkg::CSR_INDEX_BITS-1:0] index;
   logic [sfd_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/stereo_feedback_delay.sv
// stereo feedback delay top level: frame pipeline, delay stores, result register
// each frame is registered in stage one, then in the result register, before its result is offered
// one frame per cycle unless stalled, a delay just written back through the feedback forward register
// a write to the delay register holds off input while it is reduced modulo the depth
// reset clears control state only; write position and a wrap flag make unwritten entries read as zero
`timescale 1ns / 1ps
`default_nettype none

module stereo_feedback_delay #(
   parameter int DELAY_DEPTH = 131072,
   parameter int SAMPLE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   sfd_req_if.sink    req_ch,
   sfd_rsp_if.source  rsp_ch,
   sfd_csr_if.sink    csr_ch
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam logic [AW-1:0] LAST_POS  = AW'(DELAY_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(DELAY_DEPTH);

   logic [AW-1:0]                 delay;
   sfd_pkg::gain_type             gains;
   logic                          cfg_busy;

   logic [AW-1:0]                 wp_ff, wp_in;
   logic                          wrapped_ff, wrapped_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                 s1_wp_ff;
   logic                          s1_hit_ff;
   logic                          s1_fwd_ff;
   logic signed [SAMPLE_BITS-1:0] s1_left_ff, s1_right_ff;
   logic signed [SAMPLE_BITS-1:0] fb_left_last_ff, fb_right_last_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;

   logic                          s1_adv;
   logic                          req_ready;
   logic                          accept;
   logic [AW:0]                   rp_wrap;
   logic [AW-1:0]                 rd_pos;
   logic [SAMPLE_BITS-1:0]        rd_left, rd_right;
   logic signed [SAMPLE_BITS-1:0] d_left, d_right;
   logic signed [SAMPLE_BITS-1:0] fb_left, fb_right;
   logic signed [SAMPLE_BITS-1:0] mix_left, mix_right;

   sfd_csr_regs #(.DELAY_DEPTH(DELAY_DEPTH)) u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .delay  (delay),
      .gains  (gains),
      .busy   (cfg_busy)
   );

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ready    = !cfg_busy && (!s1_valid_ff || s1_adv);
   assign req_ch.ready = req_ready;
   assign accept       = req_ch.valid && req_ready;

   always_comb begin
      rp_wrap = {1'b0, wp_ff} + DEPTH_EXT - {1'b0, delay};
      if (wp_ff >= delay) begin
         rd_pos = wp_ff - delay;
      end else begin
         rd_pos = rp_wrap[AW-1:0];
      end
   end

   always_comb begin
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      if (accept) begin
         if (wp_ff == LAST_POS) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_left_ff  <= req_ch.left_in;
         s1_right_ff <= req_ch.right_in;
         s1_wp_ff    <= wp_ff;
         s1_hit_ff   <= wrapped_ff || (rd_pos < wp_ff);
         // entry written at this very edge: memory returns the old word
         s1_fwd_ff   <= s1_adv && (rd_pos == s1_wp_ff);
      end
      if (s1_adv) begin
         fb_left_last_ff  <= fb_left;
         fb_right_last_ff <= fb_right;
         rsp_left_ff      <= mix_left;
         rsp_right_ff     <= mix_right;
      end
   end

   sfd_delay_ram #(.DEPTH(DELAY_DEPTH), .WIDTH(SAMPLE_BITS)) u_left_ram (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_wp_ff),
      .wdata (fb_left),
      .re    (accept),
      .raddr (rd_pos),
      .rdata (rd_left)
   );

   sfd_delay_ram #(.DEPTH(DELAY_DEPTH), .WIDTH(SAMPLE_BITS)) u_right_ram (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_wp_ff),
      .wdata (fb_right),
      .re    (accept),
      .raddr (rd_pos),
      .rdata (rd_right)
   );

   always_comb begin
      priority if (s1_fwd_ff) begin
         d_left  = fb_left_last_ff;
         d_right = fb_right_last_ff;
      end else if (s1_hit_ff) begin
         d_left  = $signed(rd_left);
         d_right = $signed(rd_right);
      end else begin
         d_left  = '0;
         d_right = '0;
      end
   end

   sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_left_mac (
      .sample   (s1_left_ff),
      .delayed  (d_left),
      .gains    (gains),
      .feedback (fb_left),
      .mix      (mix_left)
   );

   sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_right_mac (
      .sample   (s1_right_ff),
      .delayed  (d_right),
      .gains    (gains),
      .feedback (fb_right),
      .mix      (mix_right)
   );

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_left_ff;
   assign rsp_ch.right_out = rsp_right_ff;

endmodule

`default_nettype wire

>>> src/sfd_delay_ram.sv
// delay line memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module sfd_delay_ram #(
   parameter int DEPTH = 131072,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/sfd_csr_regs.sv
// configuration registers and delay reduction modulo the depth
`timescale 1ns / 1ps
`default_nettype none

module sfd_csr_regs #(
   parameter int DELAY_DEPTH = 131072
) (
   input  logic                             clock,
   input  logic                             reset,
   sfd_csr_if.sink                          csr_ch,
   output logic [$clog2(DELAY_DEPTH)-1:0]   delay,
   output sfd_pkg::gain_type                gains,
   output logic                             busy
);

   localparam int DB = sfd_pkg::DELAY_BITS;
   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int SH = DB + AW;
   localparam int MW = DB + 2;
   localparam int PW = DB + MW;
   localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DELAY_DEPTH) - 64'd1)
                                   / 64'(DELAY_DEPTH);
   localparam logic [MW-1:0] RECIP_M   = RECIP[MW-1:0];
   localparam logic [DB-1:0] DEPTH_LOW = DB'(DELAY_DEPTH);
   localparam logic [DB-1:0] RAW_RESET = DB'(sfd_pkg::DELAY_RESET);
   localparam logic [DB-1:0] RED_RESET = DB'(sfd_pkg::DELAY_RESET % DELAY_DEPTH);

   logic [DB-1:0]     raw_ff, raw_in;
   logic [DB-1:0]     quot_ff;
   logic [DB-1:0]     red_ff, red_in;
   logic              stage1_ff, stage1_in;
   logic              stage2_ff, stage2_in;
   logic [PW-1:0]     prod;
   sfd_pkg::gain_type gains_ff, gains_in;
   logic              wr;

   assign csr_ch.ready = 1'b1;
   assign wr           = csr_ch.valid;

   always_comb begin
      raw_in    = raw_ff;
      gains_in  = gains_ff;
      stage1_in = 1'b0;
      if (wr) begin
         unique case (csr_ch.index)
            sfd_pkg::REG_DELAY: begin
               raw_in    = csr_ch.data[DB-1:0];
               stage1_in = 1'b1;
            end
            sfd_pkg::REG_FEEDBACK: gains_in.feedback = csr_ch.data[sfd_pkg::GAIN_BITS-1:0];
            sfd_pkg::REG_DRY:      gains_in.dry      = csr_ch.data[sfd_pkg::GAIN_BITS-1:0];
            sfd_pkg::REG_WET:      gains_in.wet      = csr_ch.data[sfd_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
      stage2_in = stage1_ff;
      // quotient by reciprocal, exact for every value of the register width
      prod      = PW'(raw_ff) * PW'(RECIP_M);
      red_in    = stage2_ff ? (raw_ff - DB'(quot_ff * DEPTH_LOW)) : red_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= RAW_RESET;
         red_ff    <= RED_RESET;
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         gains_ff  <= '{feedback: sfd_pkg::FEEDBACK_RESET,
                        dry:      sfd_pkg::DRY_RESET,
                        wet:      sfd_pkg::WET_RESET};
      end else begin
         raw_ff    <= raw_in;
         red_ff    <= red_in;
         stage1_ff <= stage1_in;
         stage2_ff <= stage2_in;
         gains_ff  <= gains_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage1_ff) begin
         quot_ff <= DB'(prod >> SH);
      end
   end

   assign delay = AW'(red_ff);
   assign gains = gains_ff;
   assign busy  = stage1_ff || stage2_ff;

endmodule

`default_nettype wire

>>> src/sfd_mac.sv
// per-channel feedback and mix arithmetic with rounding and saturation
`timescale 1ns / 1ps
`default_nettype none

module sfd_mac #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] delayed,
   input  sfd_pkg::gain_type             gains,
   output logic signed [SAMPLE_BITS-1:0] feedback,
   output logic signed [SAMPLE_BITS-1:0] mix
);

   localparam int FB = sfd_pkg::FRAC_BITS;
   localparam int PW = SAMPLE_BITS + sfd_pkg::GAIN_BITS + 1;
   localparam int SW = PW + 1;
   localparam int QW = SW - FB;

   logic signed [PW-1:0] p_fb;
   logic signed [PW-1:0] p_dry;
   logic signed [PW-1:0] p_wet;
   logic signed [SW-1:0] sum_fb;
   logic signed [SW-1:0] sum_mix;

   function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] t;
      logic [QW-1:0]        q;
      logic                 fits;
      t    = s + SW'(sfd_pkg::ROUND_BIAS);
      q    = t[SW-1:FB];
      fits = (&q[QW-1:SAMPLE_BITS-1]) || !(|q[QW-1:SAMPLE_BITS-1]);
      priority if (fits) begin
         return q[SAMPLE_BITS-1:0];
      end else if (q[QW-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   always_comb begin
      p_fb    = delayed * $signed({1'b0, gains.feedback});
      p_dry   = sample * $signed({1'b0, gains.dry});
      p_wet   = delayed * $signed({1'b0, gains.wet});
      sum_fb  = SW'(p_fb) + (SW'(sample) <<< FB);
      sum_mix = SW'(p_dry) + SW'(p_wet);
   end

   assign feedback = round_sat(sum_fb);
   assign mix      = round_sat(sum_mix);

endmodule

`default_nettype wire

>>> src/sfd_checker.sv
// port-level checker for the stereo feedback delay, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_feedback_delay_macros.svh"

module sfd_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_left,
   input logic [SAMPLE_BITS-1:0] rsp_right
);

   logic [2:0] pend_ff, pend_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + 3'(req_xfer) - 3'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `SFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SFD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_left) && $stable(rsp_right))
   `SFD_ASSERT_NOW(a_no_spurious, clock, reset, rsp_valid, pend_ff != 3'd0)
   `SFD_ASSERT_NOW(a_in_flight, clock, reset, 1'b1, pend_ff <= 3'd2)

endmodule

bind stereo_feedback_delay sfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_left  (rsp_ch.left_out),
   .rsp_right (rsp_ch.right_out)
);

`default_nettype wire

>>> verif/stereo_feedback_delay_tb.sv
// self-checking testbench for the stereo feedback delay: directed, random and long delay tests
`timescale 1ns / 1ps
`default_nettype none

module stereo_feedback_delay_tb;

   localparam int STORE_DEPTH = 131072;
   localparam int SAMPLE_W    = 24;
   localparam int SETTLE      = 4;
   localparam int INDEX_W     = sfd_pkg::CSR_INDEX_BITS;
   localparam int DATA_W      = sfd_pkg::CSR_DATA_BITS;
   localparam int DELAY_W     = sfd_pkg::DELAY_BITS;
   localparam int GAIN_W      = sfd_pkg::GAIN_BITS;
   localparam longint unsigned CYCLE_LIMIT = 1000000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } frame_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [INDEX_W-1:0] UNUSED_INDEX_LOW = sfd_pkg::REG_WET + 8'd1;
   localparam logic [INDEX_W-1:0] UNUSED_INDEX_HIGH = {INDEX_W{1'b1}};

   logic clock;
   logic reset;

   sfd_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_ch ();
   sfd_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_ch ();
   sfd_csr_if csr_ch ();

   stereo_feedback_delay #(
      .DELAY_DEPTH(STORE_DEPTH),
      .SAMPLE_BITS(SAMPLE_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // echo predictor state
   sample_type            echo_left_line [STORE_DEPTH];
   sample_type            echo_right_line [STORE_DEPTH];
   logic [DELAY_W-1:0]    line_head;
   logic [DELAY_W-1:0]    tap_delay;
   sfd_pkg::gain_type     gain_set;

   frame_type       echo_expected [$];
   frame_type       echo_want;
   int              error_count;
   int              burst_left;
   longint unsigned cycle_count;
   stall_mode_type  stall_mode;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(STALL_HEAVY, STALL_NONE));
      end
      case (stall_mode)
         STALL_NONE:     rsp_ch.ready <= 1'b1;
         STALL_RANDOM:   rsp_ch.ready <= ($urandom_range(3, 0) != 0);
         STALL_PERIODIC: rsp_ch.ready <= (cycle_count[2:0] >= 3'd3);
         default:        rsp_ch.ready <= ($urandom_range(7, 0) == 0);
      endcase
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (echo_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none, got left %0d right %0d",
                     $time, rsp_ch.left_out, rsp_ch.right_out);
            error_count++;
         end else begin
            echo_want = echo_expected.pop_front();
            if (rsp_ch.left_out !== echo_want.left) begin
               $display("%0t: left_out expected %0d, got %0d",
                        $time, echo_want.left, rsp_ch.left_out);
               error_count++;
            end
            if (rsp_ch.right_out !== echo_want.right) begin
               $display("%0t: right_out expected %0d, got %0d",
                        $time, echo_want.right, rsp_ch.right_out);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout with %0d results outstanding", $time, echo_expected.size());
      $display("Test completed with failures");
      $finish;
   end

   function automatic sample_type round_saturate(input longint acc);
      longint q;
      q = (acc + sfd_pkg::ROUND_BIAS) >>> sfd_pkg::FRAC_BITS;
      if (q > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (q < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return sample_type'(q);
   endfunction

   task automatic predict_echo(input sample_type left_in, input sample_type right_in);
      logic [DELAY_W-1:0] tap;
      longint             xl, xr, dl, dr, unity;
      frame_type          out;
      tap = line_head - tap_delay;
      unity = longint'(1) << sfd_pkg::FRAC_BITS;
      xl = left_in;
      xr = right_in;
      dl = echo_left_line[tap];
      dr = echo_right_line[tap];
      echo_left_line[line_head] = round_saturate(xl * unity + dl * longint'(gain_set.feedback));
      echo_right_line[line_head] = round_saturate(xr * unity + dr * longint'(gain_set.feedback));
      out.left = round_saturate(xl * longint'(gain_set.dry) + dl * longint'(gain_set.wet));
      out.right = round_saturate(xr * longint'(gain_set.dry) + dr * longint'(gain_set.wet));
      echo_expected.push_back(out);
      line_head = line_head + 1'b1;
   endtask

   task automatic send_frame(input sample_type left_in, input sample_type right_in);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.left_in <= left_in;
      req_ch.right_in <= right_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_echo(left_in, right_in);
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (echo_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] index,
                                 input logic [DATA_W-1:0] data, input bit last);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (index)
         sfd_pkg::REG_DELAY:    tap_delay = data[DELAY_W-1:0];
         sfd_pkg::REG_FEEDBACK: gain_set.feedback = data[GAIN_W-1:0];
         sfd_pkg::REG_DRY:      gain_set.dry = data[GAIN_W-1:0];
         sfd_pkg::REG_WET:      gain_set.wet = data[GAIN_W-1:0];
         default:               ;
      endcase
      if (last) csr_ch.valid <= 1'b0;
   endtask

   task automatic configure(input logic [DATA_W-1:0] delay_word,
                            input logic [DATA_W-1:0] feedback_word,
                            input logic [DATA_W-1:0] dry_word,
                            input logic [DATA_W-1:0] wet_word, input bit with_unused);
      wait_idle();
      if (with_unused) begin
         write_register(INDEX_W'($urandom_range(UNUSED_INDEX_HIGH, UNUSED_INDEX_LOW)),
                        $urandom, 1'b0);
      end
      write_register(sfd_pkg::REG_DELAY, delay_word, 1'b0);
      write_register(sfd_pkg::REG_FEEDBACK, feedback_word, 1'b0);
      write_register(sfd_pkg::REG_DRY, dry_word, 1'b0);
      write_register(sfd_pkg::REG_WET, wet_word, 1'b1);
   endtask

   function automatic sample_type pick_sample();
      int v;
      case ($urandom_range(9, 0))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return '1;
         4, 5, 6: return sample_type'($urandom);
         default: begin
            v = $urandom_range(1 << 21, 0) - (1 << 20);
            return sample_type'(v);
         end
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_delay_word();
      logic [DATA_W-1:0] word;
      word = $urandom;
      case ($urandom_range(9, 0))
         0: word[DELAY_W-1:0] = '0;
         1: word[DELAY_W-1:0] = '1;
         2: ;
         default: word[DELAY_W-1:0] = DELAY_W'($urandom_range(64, 1));
      endcase
      return word;
   endfunction

   function automatic logic [DATA_W-1:0] pick_gain_word();
      logic [DATA_W-1:0] word;
      word = $urandom;
      case ($urandom_range(7, 0))
         0: word[GAIN_W-1:0] = '0;
         1: word[GAIN_W-1:0] = '1;
         2: word[GAIN_W-1:0] = sfd_pkg::DRY_RESET;
         3: ;
         default: word[GAIN_W-1:0] = GAIN_W'($urandom_range(36000, 0));
      endcase
      return word;
   endfunction

   // defaults after reset: long delay reads silence, dry path at unity
   task automatic test_reset_values();
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame('0, '1);
      send_frame('1, '0);
      send_frame(sample_type'(1), sample_type'(-1));
   endtask

   task automatic test_saturation();
      configure(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame('0, '0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX);
   endtask

   task automatic test_zero_gains();
      configure(2, 0, 0, 0, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
   endtask

   // upper data bits dropped, giving a delay of zero, i.e. a full store length
   task automatic test_delay_zero();
      configure(32'hFFFE_0000, 32768, 32768, 32768, 1'b1);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(sample_type'(12345), sample_type'(-54321));
      send_frame(SAMPLE_MIN, '1);
   endtask

   task automatic test_delay_max();
      configure(32'h0001_FFFF, 16384, 32768, 16384, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame('1, sample_type'(1));
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
   endtask

   task automatic test_random_echo();
      repeat (15) begin
         configure(pick_delay_word(), pick_gain_word(), pick_gain_word(), pick_gain_word(),
                   $urandom_range(3, 0) == 0);
         repeat ($urandom_range(160, 80)) send_frame(pick_sample(), pick_sample());
      end
   endtask

   // delays of a full store length and one less after earlier traffic
   task automatic test_full_length_delay();
      configure(0, 24000, 16384, 32768, 1'b0);
      repeat (8) send_frame(pick_sample(), pick_sample());
      configure(32'h0001_FFFF, 16384, 32768, 40000, 1'b1);
      repeat (8) send_frame(pick_sample(), pick_sample());
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.left_in <= '0;
      req_ch.right_in <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= sfd_pkg::REG_DELAY;
      csr_ch.data <= '0;
      error_count = 0;
      burst_left = 0;
      line_head = '0;
      tap_delay = DELAY_W'(sfd_pkg::DELAY_RESET);
      gain_set.feedback = sfd_pkg::FEEDBACK_RESET;
      gain_set.dry = sfd_pkg::DRY_RESET;
      gain_set.wet = sfd_pkg::WET_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         echo_left_line[i] = '0;
         echo_right_line[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_saturation();
      test_zero_gains();
      test_delay_zero();
      test_delay_max();
      test_random_echo();
      test_full_length_delay();
      wait_idle();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
